### hw/rtl/rmd_pkg.sv
package rmd_pkg;

   localparam int LENGTH_BITS = 16;
   localparam int WORD_W      = 32;
   localparam int WORD_BYTES  = 8;
   localparam int COUNT_W     = 3;
   localparam int PREFIX_W    = $clog2(LENGTH_BITS + 1);
   localparam int REMAIN_W    = LENGTH_BITS + 1;
   localparam int LIMIT_W     = 16;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = LIMIT_W;

   localparam logic [LIMIT_W-1:0]     LIMIT_RESET      = '1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_NAME     = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_PAYLOAD  = 1'b1;

   typedef enum logic [3:0] {
      PH_REQ       = 4'd0,
      PH_OP        = 4'd1,
      PH_NLEN_PRE  = 4'd2,
      PH_NLEN_BITS = 4'd3,
      PH_NAME      = 4'd4,
      PH_DATA      = 4'd5,
      PH_PLEN_PRE  = 4'd6,
      PH_PLEN_BITS = 4'd7,
      PH_PAY       = 4'd8
   } phase_type;

   typedef enum logic [2:0] {
      K_REQ   = 3'd0,
      K_OP    = 3'd1,
      K_NLEN  = 3'd2,
      K_NBYTE = 3'd3,
      K_DATA  = 3'd4,
      K_PLEN  = 3'd5,
      K_PBYTE = 3'd6,
      K_ERR   = 3'd7
   } kind_type;

   typedef enum logic [1:0] {
      E_NONE    = 2'd0,
      E_BAD_BIT = 2'd1,
      E_PREFIX  = 2'd2,
      E_OVER    = 2'd3
   } error_type;

   typedef struct packed {
      kind_type           kind;
      logic [WORD_W-1:0]  value;
      error_type          err;
      logic               last;
   } token_type;

   typedef struct packed {
      logic [LIMIT_W-1:0] max_name;
      logic [LIMIT_W-1:0] max_payload;
   } limits_type;

endpackage

### hw/rtl/rmd_if.sv
interface rmd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

interface rmd_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         token_kind;
   logic signed [31:0] token_value;
   logic [1:0]         error_code;
   logic               message_last;

   modport source (output valid, output token_kind, output token_value, output error_code,
                   output message_last, input ready);
   modport sink (input valid, input token_kind, input token_value, input error_code,
                 input message_last, output ready);
endinterface

### hw/rtl/rpc_message_deframer.sv
// A result is registered in the result register before it appears on the rsp channel.
// Throughput: one byte per cycle while req ready is high; the parser state advances once
// per accepted transaction. A skid register beside the result register takes one more
// result while rsp stalls, so req ready only drops once both hold a result.
// Reset is synchronous and active high: the parser expects a request id, both length
// limits return to 65535 and the result and skid registers are emptied.
module rpc_message_deframer import rmd_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   rmd_req_if.sink                req_chan,
   rmd_rsp_if.source              rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   limits_type limits_ff, limits_in;
   logic       accept;
   logic       can_accept;
   logic       tok_valid;
   token_type  tok;
   logic       out_valid;
   token_type  out_tok;

   always_comb begin
      limits_in = limits_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_NAME:    limits_in.max_name    = csr_wdata[LIMIT_W-1:0];
            CSR_MAX_PAYLOAD: limits_in.max_payload = csr_wdata[LIMIT_W-1:0];
            default:         limits_in = limits_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff <= '{max_name: LIMIT_RESET, max_payload: LIMIT_RESET};
      end else begin
         limits_ff <= limits_in;
      end
   end

   assign req_chan.ready = can_accept;
   assign accept         = req_chan.valid && can_accept;

   rmd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .in_byte   (req_chan.in_byte),
      .limits    (limits_ff),
      .tok_valid (tok_valid),
      .tok       (tok)
   );

   rmd_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (accept && tok_valid),
      .push_tok   (tok),
      .can_accept (can_accept),
      .out_valid  (out_valid),
      .out_ready  (rsp_chan.ready),
      .out_tok    (out_tok)
   );

   assign rsp_chan.valid        = out_valid;
   assign rsp_chan.token_kind   = out_tok.kind;
   assign rsp_chan.token_value  = out_tok.value;
   assign rsp_chan.error_code   = out_tok.err;
   assign rsp_chan.message_last = out_tok.last;

endmodule

### hw/rtl/rmd_parser.sv
module rmd_parser import rmd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] in_byte,
   input  limits_type limits,
   output logic       tok_valid,
   output token_type  tok
);

   phase_type             phase_ff, phase_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [WORD_W-1:0]     word_ff, word_in;
   logic [PREFIX_W-1:0]   prefix_ff, prefix_in;
   logic [PREFIX_W-1:0]   bits_left_ff, bits_left_in;
   logic [REMAIN_W-1:0]   remain_ff, remain_in;

   logic [WORD_W-1:0]     byte_word;
   logic [WORD_W-1:0]     bit_word;
   logic [WORD_W-1:0]     len_value;
   logic [LIMIT_W-1:0]    limit;
   logic                  is_bit;
   logic                  word_done;
   logic                  word_arm;
   kind_type              word_kind;
   phase_type             word_next;
   logic                  len_done;
   logic                  len_name;
   logic                  fail;
   error_type             fail_code;

   assign byte_word = {word_ff[WORD_W-9:0], in_byte};
   assign bit_word  = {word_ff[WORD_W-2:0], in_byte[0]};
   assign is_bit    = (in_byte[7:1] == 7'd0);
   assign word_done = (count_ff == COUNT_W'(WORD_BYTES - 1));

   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      word_in      = word_ff;
      prefix_in    = prefix_ff;
      bits_left_in = bits_left_ff;
      remain_in    = remain_ff;
      tok_valid    = 1'b0;
      tok          = '{kind: K_REQ, value: '0, err: E_NONE, last: 1'b0};
      word_arm     = 1'b0;
      word_kind    = K_REQ;
      word_next    = PH_OP;
      len_done     = 1'b0;
      len_name     = 1'b0;
      len_value    = '0;
      limit        = limits.max_name;
      fail         = 1'b0;
      fail_code    = E_NONE;

      unique case (phase_ff) inside
         PH_OP: begin
            word_arm  = 1'b1;
            word_kind = K_OP;
            word_next = PH_NLEN_PRE;
         end
         PH_DATA: begin
            word_arm  = 1'b1;
            word_kind = K_DATA;
            word_next = PH_PLEN_PRE;
         end
         PH_NLEN_PRE, PH_PLEN_PRE: begin
            len_name = (phase_ff == PH_NLEN_PRE);
            if (!is_bit) begin
               fail      = 1'b1;
               fail_code = E_BAD_BIT;
            end else if (!in_byte[0]) begin
               if (prefix_ff >= PREFIX_W'(LENGTH_BITS)) begin
                  fail      = 1'b1;
                  fail_code = E_PREFIX;
               end else begin
                  prefix_in = prefix_ff + PREFIX_W'(1);
               end
            end else if (prefix_ff == '0) begin
               len_done = 1'b1;
            end else begin
               word_in      = WORD_W'(1);
               bits_left_in = prefix_ff;
               phase_in     = len_name ? PH_NLEN_BITS : PH_PLEN_BITS;
            end
         end
         PH_NLEN_BITS, PH_PLEN_BITS: begin
            len_name = (phase_ff == PH_NLEN_BITS);
            if (!is_bit) begin
               fail      = 1'b1;
               fail_code = E_BAD_BIT;
            end else begin
               word_in = bit_word;
               if (bits_left_ff > PREFIX_W'(1)) begin
                  bits_left_in = bits_left_ff - PREFIX_W'(1);
               end else begin
                  len_done  = 1'b1;
                  len_value = bit_word - WORD_W'(1);
               end
            end
         end
         PH_NAME: begin
            tok_valid  = 1'b1;
            tok.kind   = K_NBYTE;
            tok.value  = WORD_W'(in_byte);
            if (remain_ff <= REMAIN_W'(1)) begin
               remain_in = '0;
               phase_in  = PH_DATA;
            end else begin
               remain_in = remain_ff - REMAIN_W'(1);
            end
         end
         PH_PAY: begin
            tok_valid  = 1'b1;
            tok.kind   = K_PBYTE;
            tok.value  = WORD_W'(in_byte);
            if (remain_ff <= REMAIN_W'(1)) begin
               remain_in = '0;
               phase_in  = PH_REQ;
               tok.last  = 1'b1;
            end else begin
               remain_in = remain_ff - REMAIN_W'(1);
            end
         end
         default: begin
            // Request id, and any phase code without a meaning.
            word_arm  = 1'b1;
            word_kind = K_REQ;
            word_next = PH_OP;
            phase_in  = PH_REQ;
         end
      endcase

      if (word_arm) begin
         if (word_done) begin
            count_in  = '0;
            word_in   = '0;
            phase_in  = word_next;
            tok_valid = 1'b1;
            tok.kind  = word_kind;
            tok.value = byte_word;
         end else begin
            count_in = count_ff + COUNT_W'(1);
            word_in  = byte_word;
         end
      end

      if (len_done) begin
         prefix_in    = '0;
         bits_left_in = '0;
         word_in      = '0;
         limit        = len_name ? limits.max_name : limits.max_payload;
         if (len_value > WORD_W'(limit)) begin
            fail      = 1'b1;
            fail_code = E_OVER;
         end else begin
            remain_in = len_value[REMAIN_W-1:0];
            tok_valid = 1'b1;
            tok.kind  = len_name ? K_NLEN : K_PLEN;
            tok.value = len_value;
            if (len_name) begin
               phase_in = (len_value == '0) ? PH_DATA : PH_NAME;
            end else if (len_value == '0) begin
               phase_in = PH_REQ;
               tok.last = 1'b1;
            end else begin
               phase_in = PH_PAY;
            end
         end
      end

      // An error drops the message and starts over at the request id.
      if (fail) begin
         phase_in     = PH_REQ;
         count_in     = '0;
         word_in      = '0;
         prefix_in    = '0;
         bits_left_in = '0;
         remain_in    = '0;
         tok_valid    = 1'b1;
         tok          = '{kind: K_ERR, value: '0, err: fail_code, last: 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_REQ;
         count_ff     <= '0;
         word_ff      <= '0;
         prefix_ff    <= '0;
         bits_left_ff <= '0;
         remain_ff    <= '0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         word_ff      <= word_in;
         prefix_ff    <= prefix_in;
         bits_left_ff <= bits_left_in;
         remain_ff    <= remain_in;
      end
   end

endmodule

### hw/rtl/rmd_out_buf.sv
module rmd_out_buf import rmd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  token_type push_tok,
   output logic      can_accept,
   output logic      out_valid,
   input  logic      out_ready,
   output token_type out_tok
);

   logic      out_valid_ff, out_valid_in;
   token_type out_ff, out_in;
   logic      skid_valid_ff, skid_valid_in;
   token_type skid_ff, skid_in;
   logic      pop;

   assign pop        = out_valid_ff && out_ready;
   assign can_accept = !skid_valid_ff;
   assign out_valid  = out_valid_ff;
   assign out_tok    = out_ff;

   // A transaction that arrives while the output register is stalled parks in the skid stage.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_in       = push_tok;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_in       = push_tok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

endmodule

### hw/rtl/rmd_checker.sv
module rmd_checker import rmd_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [2:0]         token_kind,
   input logic signed [31:0] token_value,
   input logic [1:0]         error_code,
   input logic               message_last
);

   // The result register is empty in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // The input can only close while a result is waiting to be taken.
   a_ready_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input closed with no result pending");

   // An error transaction carries a cause, a zero value and ends the message.
   a_error_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && token_kind == K_ERR) |->
         (message_last && token_value == 32'sd0 && error_code != E_NONE))
      else $error("malformed error transaction");

   // Regular tokens never carry an error cause.
   a_no_cause: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && token_kind != K_ERR) |-> (error_code == E_NONE))
      else $error("error cause on a regular token");

   // A stalled result holds still.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(token_kind) && $stable(token_value) &&
          $stable(error_code) && $stable(message_last)))
      else $error("stalled result changed");

endmodule

bind rpc_message_deframer rmd_checker u_rmd_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .token_kind   (rsp_chan.token_kind),
   .token_value  (rsp_chan.token_value),
   .error_code   (rsp_chan.error_code),
   .message_last (rsp_chan.message_last)
);

### sim/tb_top.sv
module tb_top;
   import rmd_pkg::*;

   typedef struct {
      phase_type   phase;
      logic [2:0]  word_count;
      logic [31:0] shift_reg;
      int unsigned prefix_zeros;
      int unsigned bits_left;
      int unsigned remaining;
   } parser_state_type;

   logic clock = 1'b0;
   logic reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   rmd_req_if req_chan ();
   rmd_rsp_if rsp_chan ();

   rpc_message_deframer uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Limits as the block holds them, shared by the stimulus generator and the checker.
   logic [LIMIT_W-1:0] name_limit;
   logic [LIMIT_W-1:0] payload_limit;

   parser_state_type dut_state;
   parser_state_type gen_state;
   token_type     tokens_due[$];
   logic [7:0]    stream_bytes[$];
   token_type     want;
   token_type     produced;

   bit          byte_taken = 1'b0;
   int unsigned send_gap = 0;
   int unsigned send_calm = 0;
   int unsigned stall_left = 0;
   int unsigned recv_calm = 0;
   int unsigned mismatches = 0;
   int unsigned bytes_accepted = 0;
   int unsigned bytes_queued = 0;
   int unsigned tokens_checked = 0;
   int unsigned message_ends = 0;
   int unsigned error_tokens = 0;
   int unsigned limit_writes = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic parser_state_type idle_parser();
      parser_state_type st;
      st.phase = PH_REQ;
      st.word_count = '0;
      st.shift_reg = '0;
      st.prefix_zeros = 0;
      st.bits_left = 0;
      st.remaining = 0;
      return st;
   endfunction

   // Advances the parser by one byte; returns 1 when the byte completes a token.
   function automatic bit deframe_byte(inout parser_state_type st, input logic [7:0] b,
                                       output token_type tok);
      bit          is_name;
      bit          done_len;
      int unsigned len;
      error_type   fault;
      tok.kind = K_ERR;
      tok.value = '0;
      tok.err = E_NONE;
      tok.last = 1'b0;
      done_len = 1'b0;
      len = 0;
      fault = E_NONE;
      is_name = (st.phase == PH_NLEN_PRE) || (st.phase == PH_NLEN_BITS);
      case (st.phase) inside
         PH_NLEN_PRE, PH_PLEN_PRE: begin
            if (b > 8'd1) begin
               fault = E_BAD_BIT;
            end else if (b == 8'd0) begin
               if (st.prefix_zeros >= LENGTH_BITS) begin
                  fault = E_PREFIX;
               end else begin
                  st.prefix_zeros++;
                  return 1'b0;
               end
            end else if (st.prefix_zeros == 0) begin
               done_len = 1'b1;
            end else begin
               st.shift_reg = 32'd1;
               st.bits_left = st.prefix_zeros;
               st.phase = is_name ? PH_NLEN_BITS : PH_PLEN_BITS;
               return 1'b0;
            end
         end
         PH_NLEN_BITS, PH_PLEN_BITS: begin
            if (b > 8'd1) begin
               fault = E_BAD_BIT;
            end else begin
               st.shift_reg = {st.shift_reg[30:0], b[0]};
               if (st.bits_left > 1) begin
                  st.bits_left--;
                  return 1'b0;
               end
               done_len = 1'b1;
               len = st.shift_reg - 32'd1;
            end
         end
         PH_NAME: begin
            if (st.remaining <= 1) begin
               st.remaining = 0;
               st.phase = PH_DATA;
            end else begin
               st.remaining--;
            end
            tok.kind = K_NBYTE;
            tok.value = {24'h0, b};
            return 1'b1;
         end
         PH_PAY: begin
            if (st.remaining <= 1) begin
               st.remaining = 0;
               st.phase = PH_REQ;
               tok.last = 1'b1;
            end else begin
               st.remaining--;
            end
            tok.kind = K_PBYTE;
            tok.value = {24'h0, b};
            return 1'b1;
         end
         default: begin
            st.shift_reg = {st.shift_reg[23:0], b};
            if (st.word_count != 3'd7) begin
               st.word_count++;
               return 1'b0;
            end
            st.word_count = '0;
            tok.value = st.shift_reg;
            st.shift_reg = '0;
            case (st.phase)
               PH_OP: begin
                  tok.kind = K_OP;
                  st.phase = PH_NLEN_PRE;
               end
               PH_DATA: begin
                  tok.kind = K_DATA;
                  st.phase = PH_PLEN_PRE;
               end
               default: begin
                  tok.kind = K_REQ;
                  st.phase = PH_OP;
               end
            endcase
            return 1'b1;
         end
      endcase
      if (done_len) begin
         st.prefix_zeros = 0;
         st.bits_left = 0;
         st.shift_reg = '0;
         if (len > (is_name ? 32'(name_limit) : 32'(payload_limit))) begin
            fault = E_OVER;
         end else begin
            st.remaining = len;
            tok.kind = is_name ? K_NLEN : K_PLEN;
            tok.value = len;
            if (len != 0) begin
               st.phase = is_name ? PH_NAME : PH_PAY;
            end else if (is_name) begin
               st.phase = PH_DATA;
            end else begin
               st.phase = PH_REQ;
               tok.last = 1'b1;
            end
            return 1'b1;
         end
      end
      if (fault == E_NONE) return 1'b0;
      st = idle_parser();
      tok.kind = K_ERR;
      tok.err = fault;
      tok.last = 1'b1;
      return 1'b1;
   endfunction

   // Mostly short gaps, a few long ones, and now and then a stretch with none at all.
   function automatic int unsigned pick_gap(inout int unsigned calm);
      int unsigned roll;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         calm = $urandom_range(30, 120);
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic int unsigned pick_len(input int unsigned limit);
      int unsigned roll;
      int unsigned cap;
      roll = $urandom_range(0, 9);
      if (roll == 0 && limit <= 40) return limit;
      cap = (roll < 3) ? 40 : 8;
      if (cap > limit) cap = limit;
      return $urandom_range(0, cap);
   endfunction

   task automatic report_mismatch(input string field, input longint got, input longint wanted);
      if (mismatches < 20)
         $display("mismatch on %s at token %0d: got %0h, expected %0h",
                  field, tokens_checked, got, wanted);
      mismatches++;
   endtask

   // Every queued byte also runs through the generator's own parser copy, so that
   // the stimulus always knows where a message boundary is.
   task automatic send_byte(input logic [7:0] b);
      token_type ignored;
      void'(deframe_byte(gen_state, b, ignored));
      stream_bytes.push_back(b);
      bytes_queued++;
   endtask

   task automatic send_word(input logic [63:0] w);
      for (int i = 7; i >= 0; i--) send_byte(w[i*8 +: 8]);
   endtask

   task automatic send_gamma(input int unsigned code);
      int top;
      top = 0;
      for (int i = 0; i < 32; i++) if (code[i]) top = i;
      repeat (top) send_byte(8'h00);
      for (int i = top; i >= 0; i--) send_byte({7'b0, code[i]});
   endtask

   task automatic send_message(input logic [63:0] id_word, input logic [63:0] op_word,
                               input logic [63:0] data_word, input int unsigned name_len,
                               input int unsigned pay_len);
      send_word(id_word);
      send_word(op_word);
      send_gamma(name_len + 1);
      repeat (name_len) send_byte(8'($urandom_range(0, 255)));
      send_word(data_word);
      send_gamma(pay_len + 1);
      repeat (pay_len) send_byte(8'($urandom_range(0, 255)));
   endtask

   // A message that breaks inside one of its two length codes.
   task automatic send_broken();
      bit          on_payload;
      int unsigned zeros;
      int unsigned len;
      int unsigned limit;
      on_payload = 1'($urandom_range(0, 1));
      send_word(rand64());
      send_word(rand64());
      if (on_payload) begin
         len = pick_len(32'(name_limit));
         send_gamma(len + 1);
         repeat (len) send_byte(8'($urandom_range(0, 255)));
         send_word(rand64());
      end
      limit = on_payload ? 32'(payload_limit) : 32'(name_limit);
      case ($urandom_range(0, 3))
         0: begin
            zeros = $urandom_range(0, LENGTH_BITS);
            repeat (zeros) send_byte(8'h00);
            send_byte(8'($urandom_range(2, 255)));
         end
         1: begin
            zeros = $urandom_range(1, LENGTH_BITS);
            repeat (zeros) send_byte(8'h00);
            send_byte(8'h01);
            repeat ($urandom_range(0, zeros - 1)) send_byte(8'($urandom_range(0, 1)));
            send_byte(8'($urandom_range(2, 255)));
         end
         2: begin
            repeat (LENGTH_BITS + 1) send_byte(8'h00);
         end
         default: begin
            if ($urandom_range(0, 1))
               len = limit + 1 + $urandom_range(0, 3);
            else
               len = $urandom_range(limit + 1, 131070);
            send_gamma(len + 1);
         end
      endcase
   endtask

   // Brings the stream back to a message boundary after arbitrary bytes.
   task automatic resync();
      while (gen_state.phase != PH_REQ || gen_state.word_count != 0) begin
         if (gen_state.phase inside {PH_NLEN_PRE, PH_NLEN_BITS, PH_PLEN_PRE, PH_PLEN_BITS})
            send_byte(8'($urandom_range(2, 255)));
         else
            send_byte(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic wait_idle();
      do begin
         @(posedge clock);
         #1;
      end while (stream_bytes.size() != 0 || req_chan.valid || tokens_due.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(input logic [CSR_INDEX_W-1:0] idx,
                              input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_MAX_NAME)
         name_limit = value;
      else
         payload_limit = value;
      limit_writes++;
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.in_byte <= 8'h00;
      end else if (!req_chan.valid || byte_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_chan.valid <= 1'b0;
         end else if (stream_bytes.size() > 0) begin
            req_chan.valid <= 1'b1;
            req_chan.in_byte <= stream_bytes.pop_front();
            send_gap = pick_gap(send_calm);
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
         stall_left = pick_gap(recv_calm);
      end
   end

   // Results are checked before the byte of the same edge is predicted; a token passes
   // through the result register, so it never appears with the byte that completes it.
   always @(posedge clock) begin
      byte_taken = 1'b0;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (tokens_due.size() == 0) begin
               report_mismatch("token with nothing expected", 64'(rsp_chan.token_kind), 0);
            end else begin
               want = tokens_due.pop_front();
               if (rsp_chan.token_kind !== want.kind)
                  report_mismatch("token_kind", 64'(rsp_chan.token_kind), 64'(want.kind));
               if (rsp_chan.token_value !== want.value)
                  report_mismatch("token_value", 64'(rsp_chan.token_value), 64'(want.value));
               if (rsp_chan.error_code !== want.err)
                  report_mismatch("error_code", 64'(rsp_chan.error_code), 64'(want.err));
               if (rsp_chan.message_last !== want.last)
                  report_mismatch("message_last", 64'(rsp_chan.message_last),
                                  64'(want.last));
               if (want.last) message_ends++;
               if (want.kind == K_ERR) error_tokens++;
            end
            tokens_checked++;
         end
         if (req_chan.valid && req_chan.ready) begin
            byte_taken = 1'b1;
            bytes_accepted++;
            if (deframe_byte(dut_state, req_chan.in_byte, produced))
               tokens_due.push_back(produced);
         end
      end
   end

   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end

   initial begin
      int unsigned roll;
      int unsigned target;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      req_chan.in_byte = 8'h00;
      rsp_chan.ready = 1'b0;
      name_limit = LIMIT_RESET;
      payload_limit = LIMIT_RESET;
      dut_state = idle_parser();
      gen_state = idle_parser();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Field extremes, empty and single-byte name and payload, at the reset limits.
      send_message(64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_8000_0000, 0, 0);
      send_message(64'h7FFF_FFFF, 64'h1234_5678_9ABC_DEF0, 64'hFFFF_FFFF_7FFF_FFFF, 1, 1);
      send_word(rand64());
      send_word(rand64());
      send_gamma(4);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h80);
      send_word(rand64());
      send_gamma(3);
      send_byte(8'h7F);
      send_byte(8'h01);
      // Bad code byte at the start of the name prefix.
      send_word(rand64());
      send_word(rand64());
      send_byte(8'h02);
      // Bad code byte among the payload length bits.
      send_word(rand64());
      send_word(rand64());
      send_gamma(1);
      send_word(rand64());
      send_byte(8'h00);
      send_byte(8'h01);
      send_byte(8'hFF);
      // Prefix one zero too long, on the name and then on the payload.
      send_word(rand64());
      send_word(rand64());
      repeat (LENGTH_BITS + 1) send_byte(8'h00);
      send_word(rand64());
      send_word(rand64());
      send_gamma(1);
      send_word(rand64());
      repeat (LENGTH_BITS + 1) send_byte(8'h00);
      // Longest codes, both above the widest limit.
      send_word(rand64());
      send_word(rand64());
      send_gamma(65537);
      send_word(rand64());
      send_word(rand64());
      send_gamma(1);
      send_word(rand64());
      send_gamma(131071);
      wait_idle();

      // Tightest limits: lengths at the limit pass, one above fails.
      write_limit(CSR_MAX_NAME, 16'd1);
      write_limit(CSR_MAX_PAYLOAD, 16'd0);
      send_message(rand64(), rand64(), rand64(), 1, 0);
      send_word(rand64());
      send_word(rand64());
      send_gamma(3);
      send_message(rand64(), rand64(), rand64(), 0, 1);
      // The payload byte after the rejected length starts a new request id.
      resync();
      wait_idle();

      write_limit(CSR_MAX_NAME, 16'hFFFF);
      write_limit(CSR_MAX_PAYLOAD, 16'hFFFF);
      send_message(rand64(), rand64(), rand64(), 4, 3);
      wait_idle();

      for (int phase_no = 0; phase_no < 4; phase_no++) begin
         case (phase_no)
            0: begin
               write_limit(CSR_MAX_NAME, 16'($urandom_range(1, 24)));
               write_limit(CSR_MAX_PAYLOAD, 16'($urandom_range(0, 24)));
            end
            1: begin
               write_limit(CSR_MAX_NAME, 16'hFFFF);
               write_limit(CSR_MAX_PAYLOAD, 16'($urandom_range(0, 8)));
            end
            2: begin
               write_limit(CSR_MAX_NAME, 16'($urandom_range(1, 6)));
               write_limit(CSR_MAX_PAYLOAD, 16'hFFFF);
            end
            default: begin
               write_limit(CSR_MAX_NAME, 16'($urandom_range(1, 65535)));
               write_limit(CSR_MAX_PAYLOAD, 16'($urandom_range(0, 65535)));
            end
         endcase
         target = bytes_queued + 75;
         while (bytes_queued < target) begin
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
               send_message(rand64(), rand64(), rand64(), pick_len(32'(name_limit)),
                            pick_len(32'(payload_limit)));
            end else if (roll < 90) begin
               send_broken();
            end else begin
               repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(0, 255)));
               resync();
            end
         end
         wait_idle();
      end

      $display("run covered %0d bytes in, %0d tokens out, %0d message ends, %0d error tokens",
               bytes_accepted, tokens_checked, message_ends, error_tokens);
      $display("length limits were rewritten %0d times across the run", limit_writes);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
